// File: hw/rtl/tsaof_pkg.sv
// Shared widths, register indexes and control structs of the audio output filter.
package tsaof_pkg;

    // Fraction bits of samples, coefficients and section histories
    localparam int FRAC_BITS  = 16;

    localparam int RAW_W      = 20;
    localparam int STATE_W    = 24;
    localparam int PCM_W      = 16;
    localparam int GAIN_W     = 17;
    localparam int FB_W       = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int SEC_W      = 2;
    localparam int NUM_SEC    = 3;
    localparam int DIFF_W     = STATE_W + 1;
    localparam int PROD_W     = DIFF_W + FB_W;
    localparam int ACC_W      = PROD_W + 1;

    // Full-scale PCM is 2^PCM_SHIFT - 1
    localparam int PCM_SHIFT  = 15;
    localparam logic signed [PCM_W-1:0] PCM_FULL = 16'sd32767;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE        = 3'd0,
        REG_IN_HP_GAIN  = 3'd1,
        REG_IN_HP_FB    = 3'd2,
        REG_LP_GAIN     = 3'd3,
        REG_LP_FB       = 3'd4,
        REG_SPK_GAIN    = 3'd5,
        REG_SPK_FB      = 3'd6
    } cfg_reg_t;

    typedef enum logic [SEC_W-1:0] {
        SEC_IN_HP = 2'd0,
        SEC_LP    = 2'd1,
        SEC_SPK   = 2'd2
    } sec_t;

    typedef struct packed {
        logic                     mode;
        logic [GAIN_W-1:0]        in_hp_gain;
        logic signed [FB_W-1:0]   in_hp_fb;
        logic [GAIN_W-1:0]        lp_gain;
        logic signed [FB_W-1:0]   lp_fb;
        logic [GAIN_W-1:0]        spk_gain;
        logic signed [FB_W-1:0]   spk_fb;
    } coef_t;

    typedef struct packed {
        logic load_in;
        logic mul_gain;
        logic mul_fb;
        logic finish_sec;
        logic load_out;
        sec_t sec;
    } dp_cmd_t;

endpackage

// File: hw/rtl/tsaof_cfg.sv
// Configuration registers: mode and the three sections' coefficients.
module tsaof_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tsaof_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tsaof_pkg::CFG_DATA_W-1:0]     cfg_data,
    output tsaof_pkg::coef_t                     coef,
    output logic                                 hist_clr
);

    localparam logic [tsaof_pkg::GAIN_W-1:0] GAIN_ONE =
        tsaof_pkg::GAIN_W'(64'd1 << tsaof_pkg::FRAC_BITS);

    tsaof_pkg::coef_t coef_reg;
    tsaof_pkg::coef_t coef_next;

    assign cfg_ready = 1'b1;
    assign coef      = coef_reg;

    // A mode change wipes the section histories on the same beat
    assign hist_clr = cfg_valid && (cfg_index == tsaof_pkg::REG_MODE)
                      && (cfg_data[0] != coef_reg.mode);

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                tsaof_pkg::REG_MODE:       coef_next.mode       = cfg_data[0];
                tsaof_pkg::REG_IN_HP_GAIN: coef_next.in_hp_gain = cfg_data[tsaof_pkg::GAIN_W-1:0];
                tsaof_pkg::REG_IN_HP_FB:   coef_next.in_hp_fb   = $signed(cfg_data[tsaof_pkg::FB_W-1:0]);
                tsaof_pkg::REG_LP_GAIN:    coef_next.lp_gain    = cfg_data[tsaof_pkg::GAIN_W-1:0];
                tsaof_pkg::REG_LP_FB:      coef_next.lp_fb      = $signed(cfg_data[tsaof_pkg::FB_W-1:0]);
                tsaof_pkg::REG_SPK_GAIN:   coef_next.spk_gain   = cfg_data[tsaof_pkg::GAIN_W-1:0];
                tsaof_pkg::REG_SPK_FB:     coef_next.spk_fb     = $signed(cfg_data[tsaof_pkg::FB_W-1:0]);
                default:                   coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.mode       <= 1'b0;
            coef_reg.in_hp_gain <= GAIN_ONE;
            coef_reg.in_hp_fb   <= '0;
            coef_reg.lp_gain    <= GAIN_ONE;
            coef_reg.lp_fb      <= '0;
            coef_reg.spk_gain   <= GAIN_ONE;
            coef_reg.spk_fb     <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

endmodule

// File: hw/rtl/tsaof_ctrl.sv
// Sequencer: steps the shared multiplier through the three sections unless bypassed; owns the beat flags.
module tsaof_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  logic                mode,
    output tsaof_pkg::dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_GAIN  = 5'b00010,
        ST_FB    = 5'b00100,
        ST_ROUND = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    tsaof_pkg::sec_t    sec_reg;
    tsaof_pkg::sec_t    sec_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        sec_next       = sec_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.sec        = sec_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    sec_next    = tsaof_pkg::SEC_IN_HP;
                    state_next  = mode ? ST_GAIN : ST_OUT;
                end
            end
            ST_GAIN:
            begin
                cmd.mul_gain = 1'b1;
                state_next   = ST_FB;
            end
            ST_FB:
            begin
                cmd.mul_fb = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.finish_sec = 1'b1;
                case (sec_reg)
                    tsaof_pkg::SEC_SPK:
                    begin
                        state_next = ST_OUT;
                    end
                    tsaof_pkg::SEC_IN_HP:
                    begin
                        sec_next   = tsaof_pkg::SEC_LP;
                        state_next = ST_GAIN;
                    end
                    default:
                    begin
                        sec_next   = tsaof_pkg::SEC_SPK;
                        state_next = ST_GAIN;
                    end
                endcase
            end
            ST_OUT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sec_reg       <= tsaof_pkg::SEC_IN_HP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sec_reg       <= sec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second beat taken while an item is in work");

    a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !mode) |=> (state_reg == ST_OUT))
        else $error("bypass item did not go straight to output");

    a_last_sec: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish_sec && (sec_reg == tsaof_pkg::SEC_SPK)) |=> (state_reg == ST_OUT))
        else $error("speaker section finished without moving to output");

endmodule

// File: hw/rtl/tsaof_dp.sv
// Datapath: section histories, shared multiplier-accumulator, rounding and PCM scaling.
module tsaof_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  tsaof_pkg::dp_cmd_t                     cmd,
    input  tsaof_pkg::coef_t                       coef,
    input  logic                                   hist_clr,
    input  logic signed [tsaof_pkg::RAW_W-1:0]     raw_sample,
    output logic signed [tsaof_pkg::PCM_W-1:0]     pcm,
    output logic                                   clipped
);

    localparam int FRAC_BITS = tsaof_pkg::FRAC_BITS;
    localparam int STATE_W = tsaof_pkg::STATE_W;
    localparam int DIFF_W  = tsaof_pkg::DIFF_W;
    localparam int PROD_W  = tsaof_pkg::PROD_W;
    localparam int ACC_W   = tsaof_pkg::ACC_W;
    localparam int FB_W    = tsaof_pkg::FB_W;
    localparam int PCM_W   = tsaof_pkg::PCM_W;
    localparam int CL_W    = (FRAC_BITS + 2 > STATE_W + 1) ? FRAC_BITS + 2 : STATE_W + 1;
    localparam int MAG_W   = FRAC_BITS + 1;
    localparam int SC_W    = MAG_W + tsaof_pkg::PCM_SHIFT + 1;

    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (STATE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(2 ** (STATE_W - 1)));
    localparam logic signed [CL_W-1:0]  ONE    = CL_W'(1) <<< FRAC_BITS;
    localparam logic [SC_W-1:0]         SC_HALF = SC_W'(1) << (FRAC_BITS - 1);

    logic signed [STATE_W-1:0] s_reg;
    logic signed [STATE_W-1:0] s_next;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [STATE_W-1:0] prev_in_reg  [tsaof_pkg::NUM_SEC];
    logic signed [STATE_W-1:0] prev_out_reg [tsaof_pkg::NUM_SEC];
    logic signed [PCM_W-1:0]   pcm_reg;
    logic                      clip_reg;

    logic [tsaof_pkg::GAIN_W-1:0] gain_sel;
    logic signed [FB_W-1:0]       fb_sel;
    logic                         hp_sel;
    logic signed [STATE_W-1:0]    pin_sel;
    logic signed [STATE_W-1:0]    pout_sel;
    logic signed [DIFF_W-1:0]     diff;
    logic signed [DIFF_W-1:0]     mul_x;
    logic signed [FB_W-1:0]       mul_c;
    logic signed [PROD_W-1:0]     prod;
    logic signed [ACC_W-1:0]      rnd;
    logic signed [ACC_W-1:0]      sh;
    logic signed [STATE_W-1:0]    y;

    logic signed [CL_W-1:0]       sx;
    logic signed [CL_W-1:0]       abs_x;
    logic signed [CL_W-1:0]       mag_full;
    logic                         neg;
    logic                         clip_c;
    logic [MAG_W-1:0]             mag;
    logic [SC_W-1:0]              scaled;
    logic [SC_W-1:0]              rounded;
    logic [PCM_W-1:0]             q;
    logic signed [PCM_W-1:0]      pcm_c;

    assign pcm     = pcm_reg;
    assign clipped = clip_reg;

    always_comb
    begin
        case (cmd.sec)
            tsaof_pkg::SEC_IN_HP:
            begin
                gain_sel = coef.in_hp_gain;
                fb_sel   = coef.in_hp_fb;
                hp_sel   = 1'b1;
                pin_sel  = prev_in_reg[0];
                pout_sel = prev_out_reg[0];
            end
            tsaof_pkg::SEC_LP:
            begin
                gain_sel = coef.lp_gain;
                fb_sel   = coef.lp_fb;
                hp_sel   = 1'b0;
                pin_sel  = prev_in_reg[1];
                pout_sel = prev_out_reg[1];
            end
            default:
            begin
                gain_sel = coef.spk_gain;
                fb_sel   = coef.spk_fb;
                hp_sel   = 1'b1;
                pin_sel  = prev_in_reg[2];
                pout_sel = prev_out_reg[2];
            end
        endcase
    end

    // b0*(x -/+ x1) first, then subtract a1*y1 into the same accumulator
    always_comb
    begin
        diff  = hp_sel ? (DIFF_W'(s_reg) - DIFF_W'(pin_sel))
                       : (DIFF_W'(s_reg) + DIFF_W'(pin_sel));
        mul_x = cmd.mul_fb ? DIFF_W'(pout_sel) : diff;
        mul_c = cmd.mul_fb ? fb_sel : $signed({1'b0, gain_sel});
        prod  = mul_x * mul_c;

        acc_next = acc_reg;
        if (cmd.mul_gain)
        begin
            acc_next = ACC_W'(prod);
        end
        else if (cmd.mul_fb)
        begin
            acc_next = acc_reg - ACC_W'(prod);
        end
    end

    // Round half up, then saturate to the history width
    always_comb
    begin
        rnd = acc_reg + HALF;
        sh  = rnd >>> FRAC_BITS;
        if (sh > SAT_HI)
        begin
            y = SAT_HI[STATE_W-1:0];
        end
        else if (sh < SAT_LO)
        begin
            y = SAT_LO[STATE_W-1:0];
        end
        else
        begin
            y = sh[STATE_W-1:0];
        end
    end

    always_comb
    begin
        s_next = s_reg;
        if (cmd.load_in)
        begin
            s_next = STATE_W'(raw_sample);
        end
        else if (cmd.finish_sec)
        begin
            s_next = y;
        end
    end

    // Clamp to [-1, 1], scale by 2^15 - 1, round halves away from zero
    always_comb
    begin
        sx       = CL_W'(s_reg);
        neg      = s_reg[STATE_W-1];
        clip_c   = (sx > ONE) || (sx < -ONE);
        abs_x    = neg ? -sx : sx;
        mag_full = clip_c ? ONE : abs_x;
        mag      = mag_full[MAG_W-1:0];
        scaled   = (SC_W'(mag) << tsaof_pkg::PCM_SHIFT) - SC_W'(mag);
        rounded  = scaled + SC_HALF;
        q        = rounded[FRAC_BITS+PCM_W-1:FRAC_BITS];
        pcm_c    = neg ? -$signed(q) : $signed(q);
    end

    always_ff @(posedge clk)
    begin
        s_reg   <= s_next;
        acc_reg <= acc_next;
        if (cmd.load_out)
        begin
            pcm_reg  <= pcm_c;
            clip_reg <= clip_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tsaof_pkg::NUM_SEC; i++)
            begin
                prev_in_reg[i]  <= '0;
                prev_out_reg[i] <= '0;
            end
        end
        else if (hist_clr)
        begin
            for (int i = 0; i < tsaof_pkg::NUM_SEC; i++)
            begin
                prev_in_reg[i]  <= '0;
                prev_out_reg[i] <= '0;
            end
        end
        else if (cmd.finish_sec)
        begin
            for (int i = 0; i < tsaof_pkg::NUM_SEC; i++)
            begin
                if (cmd.sec == tsaof_pkg::sec_t'(i))
                begin
                    prev_in_reg[i]  <= s_reg;
                    prev_out_reg[i] <= y;
                end
            end
        end
    end

    a_hist_clear: assert property (@(posedge clk) disable iff (!rst_n)
        hist_clr |=> ((prev_out_reg[0] == '0) && (prev_out_reg[1] == '0)
                      && (prev_out_reg[2] == '0) && (prev_in_reg[0] == '0)
                      && (prev_in_reg[1] == '0) && (prev_in_reg[2] == '0)))
        else $error("mode change left history behind");

    a_clip_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && clip_c) |-> ((pcm_c == tsaof_pkg::PCM_FULL)
                                      || (pcm_c == -tsaof_pkg::PCM_FULL)))
        else $error("clipped sample not at full scale");

endmodule

// File: hw/rtl/three_section_audio_output_filter.sv
// Board mode runs each input through the three sections; bypass sends it straight out.
// A new item is taken only once the last has reached the output register; each section
// needs two passes through the single shared multiplier plus a rounding step.
// The output register frees the input side while a result waits to be taken.
// Reset: coefficients to unity gain and zero feedback, mode to bypass, histories to zero.
module three_section_audio_output_filter (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [tsaof_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tsaof_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [tsaof_pkg::RAW_W-1:0]     raw_sample,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [tsaof_pkg::PCM_W-1:0]     pcm,
    output logic                                   clipped
);

    tsaof_pkg::coef_t   coef;
    tsaof_pkg::dp_cmd_t cmd;
    logic               hist_clr;

    tsaof_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef),
        .hist_clr  (hist_clr)
    );

    tsaof_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .mode      (coef.mode),
        .cmd       (cmd)
    );

    tsaof_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .coef       (coef),
        .hist_clr   (hist_clr),
        .raw_sample (raw_sample),
        .pcm        (pcm),
        .clipped    (clipped)
    );

endmodule
